/* rtl/core/bcmd_pkg.sv */
package bcmd_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned NUM_AXES = 3;

  // Calibration schedule.
  localparam int unsigned WARMUP_SAMPLES = 10;
  localparam int unsigned CALIB_END      = 100;

  // The divider retires one quotient bit per cycle over the sample magnitude.
  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned ITER_W    = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic [THR_W-1:0]    THRESH_RESET = THR_W'(35);
  localparam logic [SAMPLE_W-1:0] SEED_RESET [NUM_AXES] = '{
    SAMPLE_W'(410), SAMPLE_W'(440), SAMPLE_W'(410)
  };

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SEED_X    = 2'd1,
    CFG_SEED_Y    = 2'd2,
    CFG_SEED_Z    = 2'd3
  } cfg_idx_e;

  // What an accepted item does.
  typedef enum logic [1:0] {
    ITEM_RECAL,
    ITEM_WARM,
    ITEM_REFINE,
    ITEM_CLASS
  } item_kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } ctrl_state_e;

  // Controls broadcast from the sequencer to every axis lane.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic upd;
  } lane_ctrl_t;

  // Per-axis classification.
  typedef struct packed {
    logic pos;
    logic neg;
  } lane_flags_t;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [SAMPLE_W-1:0] sample_z;
    logic                trigger_level;
  } in_t;

  typedef struct packed {
    logic                calibrating;
    logic                pos_x;
    logic                neg_x;
    logic                pos_y;
    logic                neg_y;
    logic                pos_z;
    logic                neg_z;
    logic                trig_active;
    logic [SAMPLE_W-1:0] base_x;
    logic [SAMPLE_W-1:0] base_y;
    logic [SAMPLE_W-1:0] base_z;
  } out_t;

endpackage

/* rtl/core/bcmd_lane.sv */
module bcmd_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcmd_pkg::lane_ctrl_t          ctrl_i,
  input  logic [bcmd_pkg::SAMPLE_W-1:0] seed_i,
  input  logic [bcmd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [bcmd_pkg::STEP_W-1:0]   k_i,
  input  logic [bcmd_pkg::THR_W-1:0]    threshold_i,
  output bcmd_pkg::lane_flags_t         flags_o,
  output logic [bcmd_pkg::SAMPLE_W-1:0] base_nxt_o
);
  import bcmd_pkg::*;

  logic [SAMPLE_W-1:0] avg_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] dq_q, dq_d;
  logic [STEP_W-1:0]   rem_q, rem_d;
  logic                neg_q;

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0] mag;
  logic [STEP_W:0]     trial;
  logic                fits;
  logic [SAMPLE_W:0]   quot;
  logic [SAMPLE_W:0]   delta;
  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W+1:0] upper;
  logic [SAMPLE_W+1:0] lower;

  // Signed distance from the baseline, split into sign and magnitude.
  assign diff = {1'b0, sample_i} - {1'b0, avg_q};
  assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

  // One restoring division step: shift in the next dividend bit and try k.
  assign trial = {rem_q, dq_q[SAMPLE_W-1]};
  assign fits  = trial >= {1'b0, k_i};

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    if (ctrl_i.load) begin
      rem_d = '0;
      dq_d  = mag;
    end else if (ctrl_i.step) begin
      rem_d = fits ? STEP_W'(trial - {1'b0, k_i}) : trial[STEP_W-1:0];
      dq_d  = {dq_q[SAMPLE_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= sample_i;
      neg_q    <= diff[SAMPLE_W];
    end
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  // Truncated quotient applied with the sign of the difference; it never
  // overshoots the sample, so the baseline stays in range.
  assign quot       = {1'b0, dq_q};
  assign delta      = neg_q ? -quot : quot;
  assign sum        = {1'b0, avg_q} + delta;
  assign base_nxt_o = ctrl_i.upd ? sum[SAMPLE_W-1:0] : avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= seed_i;
    end else if (ctrl_i.commit) begin
      avg_q <= base_nxt_o;
    end
  end

  // Dead band test; the lower bound is moved to the sample side so that a
  // negative bound needs no sign.
  assign upper       = {2'b00, avg_q} + {{(SAMPLE_W+2-THR_W){1'b0}}, threshold_i};
  assign lower       = {2'b00, sample_q} + {{(SAMPLE_W+2-THR_W){1'b0}}, threshold_i};
  assign flags_o.pos = {2'b00, sample_q} > upper;
  assign flags_o.neg = lower < {2'b00, avg_q};

endmodule

/* rtl/core/bcmd_ctrl.sv */
module bcmd_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        command_i,
  input  logic                        out_free_i,
  output logic                        in_stall_o,
  output bcmd_pkg::lane_ctrl_t        lane_ctrl_o,
  output logic                        emit_o,
  output bcmd_pkg::item_kind_e        kind_o,
  output logic [bcmd_pkg::STEP_W-1:0] k_o
);
  import bcmd_pkg::*;

  ctrl_state_e       state_q, state_d;
  item_kind_e        kind_q, kind_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] k_q, k_d;
  logic [ITER_W-1:0] iter_q;
  logic [STEP_W-1:0] step_inc;
  logic              accept;
  logic              last_iter;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign last_iter = iter_q == ITER_W'(DIV_STEPS - 1);
  assign step_inc  = step_q + STEP_W'(1);

  // Classify the incoming item and advance the calibration counter.
  always_comb begin
    kind_d = ITEM_CLASS;
    step_d = step_q;
    k_d    = k_q;
    if (command_i) begin
      kind_d = ITEM_RECAL;
      step_d = STEP_W'(1);
    end else if (step_q == '0) begin
      kind_d = ITEM_CLASS;
    end else if (step_q <= STEP_W'(WARMUP_SAMPLES)) begin
      kind_d = ITEM_WARM;
      step_d = step_inc;
    end else begin
      kind_d = ITEM_REFINE;
      k_d    = step_inc - STEP_W'(WARMUP_SAMPLES);
      step_d = (step_inc >= STEP_W'(CALIB_END)) ? '0 : step_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_W'(1);
      kind_q <= ITEM_CLASS;
      k_q    <= STEP_W'(2);
    end else if (accept) begin
      step_q <= step_d;
      kind_q <= kind_d;
      k_q    <= k_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_d == ITEM_REFINE) ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (last_iter) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    emit_o      = 1'b0;
    lane_ctrl_o = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o       = 1'b0;
        lane_ctrl_o.load = in_valid_i;
      end
      S_DIV: begin
        lane_ctrl_o.step = 1'b1;
      end
      S_EMIT: begin
        emit_o             = out_free_i;
        lane_ctrl_o.commit = out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    lane_ctrl_o.upd = kind_q == ITEM_REFINE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV) begin
        iter_q <= last_iter ? '0 : iter_q + ITER_W'(1);
      end
    end
  end

  assign kind_o = kind_q;
  assign k_o    = k_q;

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  // The calibration counter wraps to zero before reaching the end count.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(CALIB_END))
    else $error("calibration counter out of range");

  // Only refinement items divide, and then the divisor is at least two.
  a_div_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (kind_q == ITEM_REFINE) && (k_q >= STEP_W'(2)))
    else $error("division without a valid divisor");

  // The iteration count is idle outside the division.
  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_DIV |-> iter_q == '0)
    else $error("division counter left running");

endmodule

/* rtl/core/baseline_calibrated_motion_detector.sv */
// Three-axis motion detector with a self-calibrated baseline.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries either a
// sample set or a recalibrate command; every transfer yields exactly one
// result on the output channel (out_valid_o, out_stall_i, out_data_o).
// The first 10 sample sets after reset or a recalibrate command are
// warm-up; the next 89 refine the per-axis baselines, after which each
// sample set is classified against baseline plus or minus the threshold.
// Each axis has its own lane with a bit-serial restoring divider; the
// lanes run together and their flags and baselines are merged into one
// output register. A refinement item passes the divider (S_DIV) and then
// S_EMIT; every other item goes straight to S_EMIT, where the result is
// written to the output register once the slot is free. The input stalls
// until then, so an item is taken only after the last one has left.
// The user writes the threshold through cfg_we_i, cfg_idx_i and cfg_data_i
// while the block is idle, which the block does not enforce. Seed writes
// are ignored; reset loads the fixed seed defaults as the baselines.
// Reset clears the output, restarts calibration and loads the baselines.
// While the receiver stalls, the output holds and one finished item may
// wait in the sequencer behind it.
module baseline_calibrated_motion_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bcmd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bcmd_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bcmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcmd_pkg::SAMPLE_W-1:0]  cfg_data_i
);
  import bcmd_pkg::*;

  logic [THR_W-1:0]    thr_q;
  logic                trig_q;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                out_free;
  logic                emit;
  lane_ctrl_t          lane_ctrl;
  item_kind_e          kind;
  logic [STEP_W-1:0]   k;
  logic [SAMPLE_W-1:0] smp      [NUM_AXES];
  lane_flags_t         flags    [NUM_AXES];
  logic [SAMPLE_W-1:0] base_nxt [NUM_AXES];
  logic                classify;

  // Threshold register; the seeds are the fixed SEED_RESET values, so there
  // are no seed registers and seed writes have no effect.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i && (cfg_idx_i == CFG_THRESHOLD)) begin
      thr_q <= cfg_data_i[THR_W-1:0];
    end
  end

  assign smp[0] = in_data_i.sample_x;
  assign smp[1] = in_data_i.sample_y;
  assign smp[2] = in_data_i.sample_z;

  always_ff @(posedge clk_i) begin
    if (lane_ctrl.load) begin
      trig_q <= in_data_i.trigger_level;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  bcmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (in_data_i.command),
    .out_free_i  (out_free),
    .in_stall_o  (in_stall_o),
    .lane_ctrl_o (lane_ctrl),
    .emit_o      (emit),
    .kind_o      (kind),
    .k_o         (k)
  );

  // One lane per axis.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    bcmd_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl),
      .seed_i      (SEED_RESET[a]),
      .sample_i    (smp[a]),
      .k_i         (k),
      .threshold_i (thr_q),
      .flags_o     (flags[a]),
      .base_nxt_o  (base_nxt[a])
    );
  end

  // Merge the lane results into one result item.
  assign classify = kind == ITEM_CLASS;

  always_comb begin
    out_d             = '0;
    out_d.calibrating = !classify;
    out_d.pos_x       = classify && flags[0].pos;
    out_d.neg_x       = classify && flags[0].neg;
    out_d.pos_y       = classify && flags[1].pos;
    out_d.neg_y       = classify && flags[1].neg;
    out_d.pos_z       = classify && flags[2].pos;
    out_d.neg_z       = classify && flags[2].neg;
    out_d.trig_active = classify && !trig_q;
    out_d.base_x      = base_nxt[0];
    out_d.base_y      = base_nxt[1];
    out_d.base_z      = base_nxt[2];
  end

  // Output register: loaded when a result is ready and the slot is free.
  assign out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("pending result overwritten");

  // Only a classified result carries flags.
  a_flags_calib: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.calibrating) |->
      !(out_q.pos_x || out_q.neg_x || out_q.pos_y || out_q.neg_y ||
        out_q.pos_z || out_q.neg_z || out_q.trig_active))
    else $error("flags set during calibration");

  // Input is held off while an item is in flight towards the output.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> in_stall_o)
    else $error("input taken while a result was being emitted");

endmodule

/* sim/motion_result_checker.sv */
module motion_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  bcmd_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  bcmd_pkg::out_t                 out_data_i,
  input  logic                           cfg_we_i,
  input  logic [bcmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcmd_pkg::SAMPLE_W-1:0]  cfg_data_i,
  output int                             mismatches_o,
  output int                             owed_o
);
  import bcmd_pkg::*;

  // Shadow of the detector: dead band, calibration counter and baselines.
  logic [THR_W-1:0]    dead_band;
  logic [STEP_W-1:0]   calib_pos;
  logic [SAMPLE_W-1:0] baseline [NUM_AXES];

  // Results still owed by the block, oldest first.
  out_t owed_results [$];
  out_t want;

  // Advance the shadow by one accepted item and return the result it should give.
  function automatic out_t advance_detector(input in_t item);
    out_t                res;
    logic [SAMPLE_W-1:0] smp [NUM_AXES];
    logic [NUM_AXES-1:0] above;
    logic [NUM_AXES-1:0] below;
    int                  k;
    int                  s;
    int                  b;
    res   = '0;
    above = '0;
    below = '0;
    smp[0] = item.sample_x;
    smp[1] = item.sample_y;
    smp[2] = item.sample_z;
    if (item.command) begin
      // A recalibrate command restarts the count but keeps the baselines.
      calib_pos       = STEP_W'(1);
      res.calibrating = 1'b1;
    end else if (calib_pos != '0) begin
      res.calibrating = 1'b1;
      if (calib_pos <= WARMUP_SAMPLES) begin
        calib_pos = calib_pos + STEP_W'(1);
      end else begin
        // Running mean; SystemVerilog integer division truncates toward zero.
        calib_pos = calib_pos + STEP_W'(1);
        k = int'(calib_pos) - int'(WARMUP_SAMPLES);
        if (k < 1) begin
          k = 1;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
          baseline[a] = SAMPLE_W'(int'(baseline[a]) + (int'(smp[a]) - int'(baseline[a])) / k);
        end
        if (calib_pos >= CALIB_END) begin
          calib_pos = '0;
        end
      end
    end else begin
      // Signed compare, so a negative lower bound never flags a sample.
      for (int a = 0; a < NUM_AXES; a++) begin
        s = int'(smp[a]);
        b = int'(baseline[a]);
        above[a] = s > b + int'(dead_band);
        below[a] = !above[a] && (s < b - int'(dead_band));
      end
      res.trig_active = !item.trigger_level;
    end
    res.pos_x  = above[0];
    res.neg_x  = below[0];
    res.pos_y  = above[1];
    res.neg_y  = below[1];
    res.pos_z  = above[2];
    res.neg_z  = below[2];
    res.base_x = baseline[0];
    res.base_y = baseline[1];
    res.base_z = baseline[2];
    return res;
  endfunction

  function automatic void compare_field(input string field, input int exp_val,
                                        input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
      mismatches_o++;
    end
  endfunction

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Reset also restores the seeds, so the baselines always start from the defaults.
      dead_band = THRESH_RESET;
      calib_pos = STEP_W'(1);
      for (int a = 0; a < NUM_AXES; a++) begin
        baseline[a] = SEED_RESET[a];
      end
      owed_results.delete();
      mismatches_o = 0;
      owed_o       = 0;
    end else begin
      // Seed writes have no effect on the block, so only the threshold is tracked.
      if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_THRESHOLD) begin
        dead_band = cfg_data_i[THR_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, got %p",
                   $time, out_data_i);
          mismatches_o++;
        end else begin
          want = owed_results.pop_front();
          compare_field("calibrating", int'(want.calibrating),
                        int'(out_data_i.calibrating));
          compare_field("pos_x", int'(want.pos_x), int'(out_data_i.pos_x));
          compare_field("neg_x", int'(want.neg_x), int'(out_data_i.neg_x));
          compare_field("pos_y", int'(want.pos_y), int'(out_data_i.pos_y));
          compare_field("neg_y", int'(want.neg_y), int'(out_data_i.neg_y));
          compare_field("pos_z", int'(want.pos_z), int'(out_data_i.pos_z));
          compare_field("neg_z", int'(want.neg_z), int'(out_data_i.neg_z));
          compare_field("trig_active", int'(want.trig_active),
                        int'(out_data_i.trig_active));
          compare_field("base_x", int'(want.base_x), int'(out_data_i.base_x));
          compare_field("base_y", int'(want.base_y), int'(out_data_i.base_y));
          compare_field("base_z", int'(want.base_z), int'(out_data_i.base_z));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(advance_detector(in_data_i));
      end
      owed_o = owed_results.size();
    end
  end

endmodule

/* sim/baseline_calibrated_motion_detector_tb.sv */
module baseline_calibrated_motion_detector_tb;

  import bcmd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 283;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SAMPLE_W-1:0]  cfg_data_i;

  int result_errors;
  int results_owed;

  // Sender burst control and the receiver's stall bookkeeping.
  int quiet_left;
  int stall_left;
  int calm_left;
  bit hold_off_req;
  bit hold_done;

  cfg_idx_e seed_regs [NUM_AXES] = '{CFG_SEED_X, CFG_SEED_Y, CFG_SEED_Z};

  baseline_calibrated_motion_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  motion_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (result_errors),
    .owed_o       (results_owed)
  );

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk_item(input bit cmd, input int x, input int y, input int z,
                                  input bit trig);
    in_t item;
    item.command       = cmd;
    item.sample_x      = SAMPLE_W'(x);
    item.sample_y      = SAMPLE_W'(y);
    item.sample_z      = SAMPLE_W'(z);
    item.trigger_level = trig;
    return item;
  endfunction

  // One axis reading: in or just around the dead band, on its edges, or anywhere in range.
  function automatic int axis_reading(input int centre, input int band);
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = centre + int'($urandom_range(0, 2 * band + 6)) - band - 3;
    end else if (pick < 85) begin
      v = centre + ((pick % 2) ? band : -band) + int'($urandom_range(0, 4)) - 2;
    end else begin
      v = $urandom_range(0, 1023);
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // Offer one item and hold it until the transfer completes.
  task automatic send_item(input in_t item);
    int gap;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 24) == 0) begin
        quiet_left = $urandom_range(10, 60);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // The caller lowers the write enable after the last write of a batch.
  task automatic cfg_write(input cfg_idx_e idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= SAMPLE_W'(value);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, calm stretches and one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    calm_left   = 0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && calm_left == 0) begin
        if ($urandom_range(0, 15) == 0) begin
          calm_left = $urandom_range(20, 200);
        end else begin
          stall_left = idle_len();
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (calm_left > 0) calm_left--;
      end
    end
  end

  // Watchdog: give up after a long run of cycles without any transfer.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int               centre [NUM_AXES];
    logic [THR_W-1:0] thr;
    in_t              item;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_THRESHOLD;
    cfg_data_i   = '0;
    quiet_left   = 0;
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Warm-up with extreme and alternating samples, a recalibrate command,
    // a full warm-up, refinement with large swings of either sign, and a
    // recalibrate command part-way through refinement.
    send_item(mk_item(1'b0, 0, 0, 0, 1'b0));
    send_item(mk_item(1'b0, 1023, 1023, 1023, 1'b1));
    send_item(mk_item(1'b0, 'h2AA, 'h155, 'h2AA, 1'b0));
    send_item(mk_item(1'b1, 1023, 0, 1023, 1'b0));
    for (int i = 0; i < WARMUP_SAMPLES; i++) begin
      send_item(mk_item(1'b0, (i % 2) ? 1023 : 0, (i % 2) ? 0 : 1023, 'h155, 1'(i % 2)));
    end
    send_item(mk_item(1'b0, 1023, 0, 512, 1'b1));
    send_item(mk_item(1'b0, 0, 1023, 0, 1'b0));
    send_item(mk_item(1'b0, 'h155, 'h2AA, 'h155, 1'b1));
    send_item(mk_item(1'b0, 1, 1022, 511, 1'b0));
    send_item(mk_item(1'b1, 0, 0, 0, 1'b1));
    send_item(mk_item(1'b0, 1023, 1023, 1023, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only once every owed result has been delivered.
      in_valid_i <= 1'b0;
      while (results_owed != 0) @(negedge clk_i);
      case (p)
        0:       thr = '0;
        1, 2:    thr = '1;
        3:       thr = THRESH_RESET;
        5:       thr = THR_W'(1);
        default: thr = THR_W'($urandom_range(0, 255));
      endcase
      cfg_write(CFG_THRESHOLD, thr);
      cfg_write(seed_regs[p % NUM_AXES],
                (p < 3) ? 0 : (p < 6) ? 1023 : $urandom_range(0, 1023));
      cfg_we_i <= 1'b0;

      // Centres near the bottom and top of the range test the clipped bands.
      for (int a = 0; a < NUM_AXES; a++) begin
        case (p)
          1:       centre[a] = $urandom_range(0, 8);
          2:       centre[a] = $urandom_range(1015, 1023);
          default: centre[a] = $urandom_range(0, 1023);
        endcase
      end

      // Each phase recalibrates, then mostly sends sample sets around the centres.
      send_item(mk_item(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), 1'($urandom_range(0, 1))));
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) begin
          hold_off_req = 1'b1;
        end
        if ($urandom_range(0, 149) == 0) begin
          item = mk_item(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
        end else begin
          item = mk_item(1'b0, axis_reading(centre[0], int'(thr)),
                         axis_reading(centre[1], int'(thr)),
                         axis_reading(centre[2], int'(thr)), 1'($urandom_range(0, 1)));
        end
        send_item(item);
      end
    end

    // Drain the last results, then allow the block's latency before the verdict.
    in_valid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (result_errors == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
